FILE: hdl/sc3_pkg.sv
`default_nettype none
package sc3_pkg;

   localparam int DIM_BITS   = 11;
   localparam int COEF_BITS  = 8;
   localparam int PIX_BITS   = 8;
   localparam int CSR_IDX_BITS = 3;
   localparam int MIN_DIM    = 3;

   typedef struct packed {
      logic                cmd;
      logic [PIX_BITS-1:0] in_pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] out_pixel;
      logic                frame_last;
   } rsp_type;

   // read request tag that travels with the memory read
   typedef struct packed {
      logic       vld;
      logic [1:0] tap;
      logic [1:0] row;
   } rd_tag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_FINISH,
      ST_HOLD
   } state_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FRAME_HEIGHT = 3'd0,
      CSR_FRAME_WIDTH  = 3'd1,
      CSR_HCOEF_0      = 3'd2,
      CSR_HCOEF_1      = 3'd3,
      CSR_HCOEF_2      = 3'd4,
      CSR_VCOEF_0      = 3'd5,
      CSR_VCOEF_1      = 3'd6,
      CSR_VCOEF_2      = 3'd7
   } csr_idx_type;

   localparam logic       CMD_PIXEL = 1'b0;
   localparam logic       CMD_DRAIN = 1'b1;

   localparam logic [1:0] TAP_FIRST = 2'd0;
   localparam logic [1:0] TAP_LAST  = 2'd2;

endpackage
`default_nettype wire

FILE: hdl/separable_conv3_border_replicate.sv
`default_nettype none
// channel   | ports                                  | moves
// ----------+----------------------------------------+----------------------------------
// request   | req_valid, req_stall, req_payload      | cmd and in_pixel, raster order
// response  | rsp_valid, rsp_stall, rsp_payload      | out_pixel and frame_last
// csr       | csr_wr_en, csr_index, csr_wdata        | geometry and tap writes
//
// a request is taken only while the sequencer is idle; one that gives a response then
// runs the row memory read port over the nine window taps, then the tap math, and
// further requests stall until it is done, paced by the single read port of the row memory
// reset is synchronous; geometry writes restart the frame counters
// the response register lets the next request in while a response waits

module separable_conv3_border_replicate
   import sc3_pkg::*;
#(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire req_type                 req_payload,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      rsp_type                 rsp_payload,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [DIM_BITS-1:0]     csr_wdata
);

   localparam int DEPTH = 4 * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int NW    = $clog2(MAX_ROWS * MAX_COLS + 1);

   // configuration
   logic [DIM_BITS-1:0]            frame_height_ff;
   logic [DIM_BITS-1:0]            frame_width_ff;
   logic [2:0][COEF_BITS-1:0]      hcoef_ff;
   logic [2:0][COEF_BITS-1:0]      vcoef_ff;
   logic                           restart;

   // effective geometry
   logic [RW-1:0]                  h_eff;
   logic [CW-1:0]                  w_eff;

   // frame counters
   logic [RW-1:0]                  in_row_ff, in_row_in;
   logic [CW-1:0]                  in_col_ff, in_col_in;
   logic [NW-1:0]                  pix_cnt_ff, pix_cnt_in;
   logic [AW-1:0]                  wptr_ff, wptr_in;
   logic [RW-1:0]                  out_row_ff, out_row_in;
   logic [CW-1:0]                  out_col_ff, out_col_in;
   logic [AW-1:0]                  row_base_ff, row_base_in;

   // fetch sequencer
   state_type                      state_ff, state_in;
   logic [AW-1:0]                  raddr_ff, raddr_in;
   logic [1:0]                     tap_ff, tap_in;
   logic [1:0]                     row_ff, row_in;
   logic                           last_ff, last_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_type                        rsp_data_ff, rsp_data_in;

   logic                           accept;
   logic                           pix_phase;
   logic                           do_write;
   logic                           emit;
   logic                           last_pos;
   logic [CW-1:0]                  col_clamp;
   logic [AW:0]                    base_sum;
   logic [AW:0]                    step_sum;
   logic [AW:0]                    wptr_sum;
   logic [AW:0]                    rb_sum;
   logic                           rsp_free;
   logic                           load_rsp;
   logic                           issue;
   rd_tag_type                     tag_issue;
   rd_tag_type                     tag_data;
   logic [PIX_BITS-1:0]            rd_data;
   logic [PIX_BITS-1:0]            mac_result;
   logic                           mac_done;

   // saturate geometry into the supported range
   always_comb begin
      if (32'(frame_height_ff) < MIN_DIM) begin
         h_eff = RW'(MIN_DIM);
      end else if (32'(frame_height_ff) > MAX_ROWS) begin
         h_eff = RW'(MAX_ROWS);
      end else begin
         h_eff = RW'(frame_height_ff);
      end
      if (32'(frame_width_ff) < MIN_DIM) begin
         w_eff = CW'(MIN_DIM);
      end else if (32'(frame_width_ff) > MAX_COLS) begin
         w_eff = CW'(MAX_COLS);
      end else begin
         w_eff = CW'(frame_width_ff);
      end
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_height_ff <= DIM_BITS'(MIN_DIM);
         frame_width_ff  <= DIM_BITS'(MIN_DIM);
         hcoef_ff        <= {8'd0, 8'd1, 8'd0};
         vcoef_ff        <= {8'd0, 8'd1, 8'd0};
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_HCOEF_0:      hcoef_ff[0]     <= csr_wdata[COEF_BITS-1:0];
            CSR_HCOEF_1:      hcoef_ff[1]     <= csr_wdata[COEF_BITS-1:0];
            CSR_HCOEF_2:      hcoef_ff[2]     <= csr_wdata[COEF_BITS-1:0];
            CSR_VCOEF_0:      vcoef_ff[0]     <= csr_wdata[COEF_BITS-1:0];
            CSR_VCOEF_1:      vcoef_ff[1]     <= csr_wdata[COEF_BITS-1:0];
            CSR_VCOEF_2:      vcoef_ff[2]     <= csr_wdata[COEF_BITS-1:0];
            default:          ;
         endcase
      end
   end

   assign restart = csr_wr_en &&
                    ((csr_idx_type'(csr_index) == CSR_FRAME_HEIGHT) ||
                     (csr_idx_type'(csr_index) == CSR_FRAME_WIDTH));

   // request decode
   assign accept    = req_valid && !req_stall;
   assign pix_phase = in_row_ff < h_eff;
   assign do_write  = accept && pix_phase && (req_payload.cmd == CMD_PIXEL);

   // left window column, replicated at both edges
   always_comb begin
      if (out_col_ff == '0) begin
         col_clamp = '0;
      end else begin
         col_clamp = out_col_ff - CW'(1);
      end
      if (col_clamp > w_eff - CW'(MIN_DIM)) begin
         col_clamp = w_eff - CW'(MIN_DIM);
      end
   end

   assign last_pos = (out_row_ff >= h_eff - RW'(1)) && (out_col_ff >= w_eff - CW'(1));

   // modular pointer adds, each sum stays below twice the depth
   assign base_sum = (AW+1)'(row_base_ff) + (AW+1)'(col_clamp);
   assign wptr_sum = (AW+1)'(wptr_ff) + (AW+1)'(1);
   assign rb_sum   = (AW+1)'(row_base_ff) + (AW+1)'(w_eff);
   assign step_sum = (tap_ff == TAP_LAST) ?
                     (AW+1)'(raddr_ff) + (AW+1)'(w_eff - CW'(2)) :
                     (AW+1)'(raddr_ff) + (AW+1)'(1);

   // frame counters and output position
   always_comb begin
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      pix_cnt_in  = pix_cnt_ff;
      wptr_in     = wptr_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      row_base_in = row_base_ff;
      emit        = 1'b0;

      if (do_write) begin
         wptr_in    = (wptr_sum >= (AW+1)'(DEPTH)) ? AW'(wptr_sum - (AW+1)'(DEPTH))
                                                   : AW'(wptr_sum);
         pix_cnt_in = pix_cnt_ff + NW'(1);
         if (in_col_ff + CW'(1) >= w_eff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
         // enough rows buffered to cover the first window
         emit = 32'(pix_cnt_in) >= 2 * 32'(w_eff) + 3;
      end else if (accept && !pix_phase) begin
         emit = 1'b1;
      end

      if (emit) begin
         if (last_pos) begin
            in_row_in   = '0;
            in_col_in   = '0;
            pix_cnt_in  = '0;
            wptr_in     = '0;
            out_row_in  = '0;
            out_col_in  = '0;
            row_base_in = '0;
         end else if (out_col_ff + CW'(1) >= w_eff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + RW'(1);
            // window top row moves only between the replicated edges
            if ((out_row_in >= RW'(2)) && (out_row_in <= h_eff - RW'(2))) begin
               row_base_in = (rb_sum >= (AW+1)'(DEPTH)) ? AW'(rb_sum - (AW+1)'(DEPTH))
                                                        : AW'(rb_sum);
            end
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end

      if (restart) begin
         in_row_in   = '0;
         in_col_in   = '0;
         pix_cnt_in  = '0;
         wptr_in     = '0;
         out_row_in  = '0;
         out_col_in  = '0;
         row_base_in = '0;
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (emit) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if ((tap_ff == TAP_LAST) && (row_ff == TAP_LAST)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (mac_done) begin
               state_in = rsp_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      issue     = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_FETCH:  issue     = 1'b1;
         ST_FINISH: load_rsp  = mac_done && rsp_free;
         ST_HOLD:   load_rsp  = rsp_free;
         default:   req_stall = 1'b1;
      endcase
   end

   // read address walk over the 3x3 window
   always_comb begin
      raddr_in = raddr_ff;
      tap_in   = tap_ff;
      row_in   = row_ff;
      last_in  = last_ff;
      if (emit) begin
         raddr_in = (base_sum >= (AW+1)'(DEPTH)) ? AW'(base_sum - (AW+1)'(DEPTH))
                                                 : AW'(base_sum);
         tap_in   = TAP_FIRST;
         row_in   = TAP_FIRST;
         last_in  = last_pos;
      end else if (issue) begin
         raddr_in = (step_sum >= (AW+1)'(DEPTH)) ? AW'(step_sum - (AW+1)'(DEPTH))
                                                 : AW'(step_sum);
         if (tap_ff == TAP_LAST) begin
            tap_in = TAP_FIRST;
            row_in = row_ff + 2'd1;
         end else begin
            tap_in = tap_ff + 2'd1;
         end
      end
   end

   assign tag_issue.vld = issue;
   assign tag_issue.tap = tap_ff;
   assign tag_issue.row = row_ff;

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_pixel  = mac_result;
         rsp_data_in.frame_last = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         pix_cnt_ff   <= '0;
         wptr_ff      <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         row_base_ff  <= '0;
         tap_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         pix_cnt_ff   <= pix_cnt_in;
         wptr_ff      <= wptr_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         row_base_ff  <= row_base_in;
         tap_ff       <= tap_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raddr_ff    <= raddr_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   sc3_row_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_row_mem (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (do_write),
      .wr_addr    (wptr_ff),
      .wr_data    (req_payload.in_pixel),
      .rd_tag     (tag_issue),
      .rd_addr    (raddr_ff),
      .rd_data    (rd_data),
      .rd_tag_out (tag_data)
   );

   sc3_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .tag    (tag_data),
      .data   (rd_data),
      .hcoef  (hcoef_ff),
      .vcoef  (vcoef_ff),
      .result (mac_result),
      .done   (mac_done)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTHESIS
   // the tap math only finishes while the sequencer waits for it
   a_done_in_finish: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_FINISH))
      else $error("tap result outside finish state");

   // input column never reaches the row width
   a_in_col_range: assert property (@(posedge clock) disable iff (reset)
      in_col_ff < w_eff)
      else $error("input column out of range");

   // write pointer stays inside the row memory
   a_wptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(wptr_ff) < DEPTH)
      else $error("write pointer out of range");

   // a response can only be loaded once the register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load_rsp)
      else $error("response overwritten while stalled");
`endif

endmodule
`default_nettype wire

FILE: hdl/sc3_row_mem.sv
`default_nettype none
module sc3_row_mem
   import sc3_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire logic [PIX_BITS-1:0] wr_data,
   input  wire rd_tag_type          rd_tag,
   input  wire logic [AW-1:0]       rd_addr,
   output      logic [PIX_BITS-1:0] rd_data,
   output      rd_tag_type          rd_tag_out
);

   logic [PIX_BITS-1:0] mem [DEPTH];
   logic [PIX_BITS-1:0] rd_data_ff;
   rd_tag_type          rd_tag_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   // tag follows the data by the read latency
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tag_ff <= '0;
      end else begin
         rd_tag_ff <= rd_tag;
      end
   end

   assign rd_data    = rd_data_ff;
   assign rd_tag_out = rd_tag_ff;

endmodule
`default_nettype wire

FILE: hdl/sc3_mac.sv
`default_nettype none
module sc3_mac
   import sc3_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rd_tag_type                    tag,
   input  wire logic [PIX_BITS-1:0]           data,
   input  wire logic [2:0][COEF_BITS-1:0]     hcoef,
   input  wire logic [2:0][COEF_BITS-1:0]     vcoef,
   output      logic [PIX_BITS-1:0]           result,
   output      logic                          done
);

   logic [COEF_BITS-1:0]          hc;
   logic [COEF_BITS-1:0]          vc;
   logic [PIX_BITS+COEF_BITS-1:0] hprod;
   logic [PIX_BITS+COEF_BITS-1:0] vprod;
   logic [PIX_BITS-1:0]           hsum_in;
   logic [PIX_BITS-1:0]           vsum_in;
   logic [PIX_BITS-1:0]           hacc_ff;
   logic [PIX_BITS-1:0]           hrow_ff;
   logic                          hrow_vld_ff;
   logic [1:0]                    hrow_k_ff;
   logic [PIX_BITS-1:0]           vacc_ff;
   logic                          done_ff;

   always_comb begin
      case (tag.tap)
         2'd0:    hc = hcoef[0];
         2'd1:    hc = hcoef[1];
         2'd2:    hc = hcoef[2];
         default: hc = '0;
      endcase
      case (hrow_k_ff)
         2'd0:    vc = vcoef[0];
         2'd1:    vc = vcoef[1];
         2'd2:    vc = vcoef[2];
         default: vc = '0;
      endcase
   end

   // horizontal tap, wraps to pixel width
   assign hprod   = hc * data;
   assign hsum_in = ((tag.tap == TAP_FIRST) ? '0 : hacc_ff) + hprod[PIX_BITS-1:0];

   // vertical tap on the registered row sum
   assign vprod   = vc * hrow_ff;
   assign vsum_in = ((hrow_k_ff == TAP_FIRST) ? '0 : vacc_ff) + vprod[PIX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (tag.vld) begin
         hacc_ff <= hsum_in;
         if (tag.tap == TAP_LAST) begin
            hrow_ff   <= hsum_in;
            hrow_k_ff <= tag.row;
         end
      end
      if (hrow_vld_ff) begin
         vacc_ff <= vsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hrow_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         hrow_vld_ff <= tag.vld && (tag.tap == TAP_LAST);
         done_ff     <= hrow_vld_ff && (hrow_k_ff == TAP_LAST);
      end
   end

   assign result = vacc_ff;
   assign done   = done_ff;

endmodule
`default_nettype wire
